// ----- hdl/csac_pkg.sv -----
// Package: operation codes, beat payload types and BCD constants of the 6502-class ALU.
package csac_pkg;

  typedef enum logic [2:0] {
    OP_ASL = 3'd0,
    OP_LSR = 3'd1,
    OP_ROL = 3'd2,
    OP_ROR = 3'd3,
    OP_ADC = 3'd4,
    OP_SBC = 3'd5,
    OP_CMP = 3'd6
  } alu_op_e;

  localparam int unsigned DataW = 8;

  // BCD correction constants
  localparam logic [5:0] BcdLoMax = 6'h09;
  localparam logic [5:0] BcdLoAdj = 6'h06;
  localparam logic [9:0] BcdHiMax = 10'h09F;
  localparam logic [9:0] BcdHiAdj = 10'h060;
  localparam logic [3:0] BcdNibAdj = 4'h6;

  typedef struct packed {
    logic [2:0]       command;
    logic [DataW-1:0] register_value;
    logic [DataW-1:0] operand;
    logic             carry_in;
    logic             decimal_mode;
    logic             overflow_in;
  } alu_req_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             negative_flag;
    logic             zero_flag;
    logic             carry_flag;
    logic             overflow_flag;
  } alu_rsp_t;

endpackage

// ----- hdl/csac_if.sv -----
// Interfaces: request and response channels of the ALU with valid/ready handshake.
interface csac_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] register_value;
  logic [7:0] operand;
  logic       carry_in;
  logic       decimal_mode;
  logic       overflow_in;

  modport source (
    output valid, command, register_value, operand, carry_in, decimal_mode, overflow_in,
    input  ready
  );
  modport sink (
    input  valid, command, register_value, operand, carry_in, decimal_mode, overflow_in,
    output ready
  );
endinterface

interface csac_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       negative_flag;
  logic       zero_flag;
  logic       carry_flag;
  logic       overflow_flag;

  modport source (
    output valid, result, negative_flag, zero_flag, carry_flag, overflow_flag,
    input  ready
  );
  modport sink (
    input  valid, result, negative_flag, zero_flag, carry_flag, overflow_flag,
    output ready
  );
endinterface

// ----- hdl/csac_core.sv -----
// ALU datapath: shifts, rotates, binary/BCD add and subtract, compare.
module csac_core (
  input  csac_pkg::alu_req_t req_i,
  output csac_pkg::alu_rsp_t rsp_o
);
  import csac_pkg::*;

  logic [7:0] a, m;
  logic [8:0] bin_sum;
  logic [7:0] addend;
  logic       bin_v;
  logic [5:0] adc_lo;
  logic [9:0] adc_s;
  logic [9:0] sbc_lo;
  logic [9:0] sbc_s;
  logic [8:0] cmp_diff;
  logic [7:0] res;
  logic [7:0] nz_src;
  logic       c_out;
  logic       v_out;

  assign a = req_i.register_value;
  assign m = req_i.operand;

  // SBC adds the inverted operand
  assign addend  = (req_i.command == OP_SBC) ? ~m : m;
  assign bin_sum = {1'b0, a} + {1'b0, addend} + {8'd0, req_i.carry_in};
  assign bin_v   = (a[7] ^ bin_sum[7]) & (addend[7] ^ bin_sum[7]);

  // decimal ADC
  always_comb begin
    adc_lo = {2'b00, a[3:0]} + {2'b00, m[3:0]} + {5'd0, req_i.carry_in};
    if (adc_lo > BcdLoMax) begin
      adc_lo = adc_lo + BcdLoAdj;
    end
    adc_s = {2'b00, a[7:4], 4'h0} + {2'b00, m[7:4], 4'h0} + {4'd0, adc_lo};
    if (adc_s > BcdHiMax) begin
      adc_s = adc_s + BcdHiAdj;
    end
  end

  // decimal SBC, two's complement in 10 bits
  always_comb begin
    sbc_lo = {6'd0, a[3:0]} - {6'd0, m[3:0]} + {9'd0, req_i.carry_in} - 10'd1;
    if (sbc_lo[9]) begin
      sbc_lo = {6'h3F, sbc_lo[3:0] - BcdNibAdj};
    end
    sbc_s = {2'b00, a[7:4], 4'h0} - {2'b00, m[7:4], 4'h0} + sbc_lo;
    if (sbc_s[9]) begin
      sbc_s = sbc_s - BcdHiAdj;
    end
  end

  assign cmp_diff = {1'b0, a} - {1'b0, m};

  always_comb begin
    res    = m;
    nz_src = m;
    c_out  = req_i.carry_in;
    v_out  = req_i.overflow_in;
    case (req_i.command)
      OP_ASL: begin
        res   = {m[6:0], 1'b0};
        c_out = m[7];
      end
      OP_LSR: begin
        res   = {1'b0, m[7:1]};
        c_out = m[0];
      end
      OP_ROL: begin
        res   = {m[6:0], req_i.carry_in};
        c_out = m[7];
      end
      OP_ROR: begin
        res   = {req_i.carry_in, m[7:1]};
        c_out = m[0];
      end
      OP_ADC: begin
        v_out = bin_v;
        if (req_i.decimal_mode) begin
          res   = adc_s[7:0];
          c_out = |adc_s[9:8];
        end else begin
          res   = bin_sum[7:0];
          c_out = bin_sum[8];
        end
      end
      OP_SBC: begin
        v_out = bin_v;
        c_out = bin_sum[8];
        res   = req_i.decimal_mode ? sbc_s[7:0] : bin_sum[7:0];
      end
      OP_CMP: begin
        res   = a;
        c_out = ~cmp_diff[8];
      end
      default: begin
        res = m;
      end
    endcase
    // flags follow the difference for CMP, the result otherwise
    nz_src = (req_i.command == OP_CMP) ? cmp_diff[7:0] : res;
  end

  assign rsp_o.result        = res;
  assign rsp_o.negative_flag = nz_src[7];
  assign rsp_o.zero_flag     = (nz_src == 8'd0);
  assign rsp_o.carry_flag    = c_out;
  assign rsp_o.overflow_flag = v_out;

endmodule

// ----- hdl/cpu_alu_shift_add_compare.sv -----
// Top level: 6502-class ALU with an input register, datapath and result register.
// Every operation (ASL, LSR, ROL, ROR, ADC, SBC with BCD correction, CMP) is
// combinational in the datapath between the input register and the result register,
// so a beat is accepted in every cycle while the request side does not stall, and each
// request passes through the input register and then the result register. A stalled
// result beat holds the result stage, and once the input stage is also full the request
// side stalls. The two register stages advance independently, so a waiting result does
// not block a new request while the input stage is free.
module cpu_alu_shift_add_compare (
  input logic        clk_i,
  input logic        rst_ni,
  csac_req_if.sink   in_i,
  csac_rsp_if.source out_o
);
  import csac_pkg::*;

  alu_req_t req_d, req_q;
  alu_rsp_t rsp_d, rsp_q;
  logic     in_valid_q;
  logic     out_valid_q;
  logic     s1_ready;
  logic     s2_ready;

  assign s2_ready = ~out_valid_q | out_o.ready;
  assign s1_ready = ~in_valid_q | s2_ready;
  assign in_i.ready = s1_ready;

  assign req_d.command        = in_i.command;
  assign req_d.register_value = in_i.register_value;
  assign req_d.operand        = in_i.operand;
  assign req_d.carry_in       = in_i.carry_in;
  assign req_d.decimal_mode   = in_i.decimal_mode;
  assign req_d.overflow_in    = in_i.overflow_in;

  csac_core u_core (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      req_q <= req_d;
    end
    if (s2_ready && in_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result        = rsp_q.result;
  assign out_o.negative_flag = rsp_q.negative_flag;
  assign out_o.zero_flag     = rsp_q.zero_flag;
  assign out_o.carry_flag    = rsp_q.carry_flag;
  assign out_o.overflow_flag = rsp_q.overflow_flag;

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> in_valid_q)
    else $error("accepted beat not held in input stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !s2_ready |=> in_valid_q && $stable(req_q))
    else $error("input stage lost a beat while stalled");

  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && s2_ready |=> out_valid_q)
    else $error("advanced beat missing from result stage");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result beat without a request");

endmodule

// ----- test/testbench.sv -----
// Testbench: random and directed request beats through the 6502-class ALU, results checked in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csac_pkg::*;

  // The enum leaves the top code unnamed; the ALU treats it as a pass-through.
  localparam logic [2:0] OpNop = 3'd7;
  localparam int unsigned NumRandom = 550;
  localparam int unsigned HoldOffCycles = 120;

  logic clk_i = 1'b0;
  logic rst_ni;

  csac_req_if req_if ();
  csac_rsp_if rsp_if ();

  cpu_alu_shift_add_compare dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  alu_req_t pending_reqs[$];
  alu_rsp_t expected_rsps[$];

  int unsigned err_count = 0;
  int unsigned sent_count = 0;
  int unsigned bcd_count = 0;
  int unsigned nop_count = 0;
  int unsigned checked_count = 0;
  int unsigned holdoff_total = 0;

  // ALU behavior: result and N/Z/C/V for one request.
  function automatic alu_rsp_t alu_predict(alu_req_t rq);
    logic [7:0] addend;
    logic [7:0] res;
    logic [7:0] nz_src;
    logic [8:0] sum;
    logic       ovf;
    int         lo;
    int         dsum;
    alu_rsp_t   rsp;

    rsp.carry_flag = rq.carry_in;
    rsp.overflow_flag = rq.overflow_in;
    res = rq.operand;
    addend = (rq.command == OP_SBC) ? ~rq.operand : rq.operand;
    sum = {1'b0, rq.register_value} + {1'b0, addend} + {8'd0, rq.carry_in};
    ovf = (rq.register_value[7] ^ sum[7]) & (addend[7] ^ sum[7]);
    nz_src = 8'd0;
    case (rq.command)
      OP_ASL: begin
        res = {rq.operand[6:0], 1'b0};
        rsp.carry_flag = rq.operand[7];
      end
      OP_LSR: begin
        res = {1'b0, rq.operand[7:1]};
        rsp.carry_flag = rq.operand[0];
      end
      OP_ROL: begin
        res = {rq.operand[6:0], rq.carry_in};
        rsp.carry_flag = rq.operand[7];
      end
      OP_ROR: begin
        res = {rq.carry_in, rq.operand[7:1]};
        rsp.carry_flag = rq.operand[0];
      end
      OP_ADC: begin
        res = sum[7:0];
        rsp.carry_flag = sum[8];
        rsp.overflow_flag = ovf;
        if (rq.decimal_mode) begin
          lo = int'(rq.register_value[3:0]) + int'(rq.operand[3:0]) + int'(rq.carry_in);
          if (lo > 9) lo = lo + 6;
          dsum = int'(rq.register_value[7:4]) * 16 + int'(rq.operand[7:4]) * 16 + lo;
          if (dsum > 'h9F) dsum = dsum + 'h60;
          res = dsum[7:0];
          rsp.carry_flag = (dsum > 'hFF);
        end
      end
      OP_SBC: begin
        res = sum[7:0];
        rsp.carry_flag = sum[8];
        rsp.overflow_flag = ovf;
        if (rq.decimal_mode) begin
          lo = int'(rq.register_value[3:0]) - int'(rq.operand[3:0]) + int'(rq.carry_in) - 1;
          if (lo < 0) lo = ((lo - 6) & 'hF) - 'h10;
          dsum = int'(rq.register_value[7:4]) * 16 - int'(rq.operand[7:4]) * 16 + lo;
          if (dsum < 0) dsum = dsum - 'h60;
          res = dsum[7:0];
        end
      end
      OP_CMP: begin
        // flags come from the difference, the register passes through
        nz_src = rq.register_value - rq.operand;
        res = rq.register_value;
        rsp.carry_flag = (rq.register_value >= rq.operand);
      end
      default: ;
    endcase
    if (rq.command != OP_CMP) nz_src = res;
    rsp.result = res;
    rsp.negative_flag = nz_src[7];
    rsp.zero_flag = (nz_src == 8'd0);
    return rsp;
  endfunction

  task automatic queue_request(logic [2:0] cmd, logic [7:0] a, logic [7:0] m,
                               logic c, logic d, logic v);
    alu_req_t rq;
    rq.command = cmd;
    rq.register_value = a;
    rq.operand = m;
    rq.carry_in = c;
    rq.decimal_mode = d;
    rq.overflow_in = v;
    pending_reqs.push_back(rq);
  endtask

  // Driver: bursts of beats with random gaps; holds the payload while stalled.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    alu_req_t rq;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.command <= 3'd0;
      req_if.register_value <= 8'd0;
      req_if.operand <= 8'd0;
      req_if.carry_in <= 1'b0;
      req_if.decimal_mode <= 1'b0;
      req_if.overflow_in <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        rq = pending_reqs.pop_front();
        expected_rsps.push_back(alu_predict(rq));
        sent_count++;
        if (rq.decimal_mode && (rq.command == OP_ADC || rq.command == OP_SBC)) bcd_count++;
        if (rq.command == OpNop) nop_count++;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          burst_left--;
          req_if.valid <= 1'b1;
          req_if.command <= pending_reqs[0].command;
          req_if.register_value <= pending_reqs[0].register_value;
          req_if.operand <= pending_reqs[0].operand;
          req_if.carry_in <= pending_reqs[0].carry_in;
          req_if.decimal_mode <= pending_reqs[0].decimal_mode;
          req_if.overflow_in <= pending_reqs[0].overflow_in;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat, and drives ready from its own stall pattern.
  int unsigned mon_cycle = 0;
  int unsigned holdoff_left = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    alu_rsp_t want;
    logic     next_ready;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result beat with no request outstanding");
          err_count++;
        end else begin
          want = expected_rsps.pop_front();
          checked_count++;
          if (rsp_if.result !== want.result) begin
            $error("result: expected %h, got %h", want.result, rsp_if.result);
            err_count++;
          end
          if (rsp_if.negative_flag !== want.negative_flag) begin
            $error("negative_flag: expected %b, got %b", want.negative_flag,
                   rsp_if.negative_flag);
            err_count++;
          end
          if (rsp_if.zero_flag !== want.zero_flag) begin
            $error("zero_flag: expected %b, got %b", want.zero_flag, rsp_if.zero_flag);
            err_count++;
          end
          if (rsp_if.carry_flag !== want.carry_flag) begin
            $error("carry_flag: expected %b, got %b", want.carry_flag, rsp_if.carry_flag);
            err_count++;
          end
          if (rsp_if.overflow_flag !== want.overflow_flag) begin
            $error("overflow_flag: expected %b, got %b", want.overflow_flag,
                   rsp_if.overflow_flag);
            err_count++;
          end
        end
      end

      mon_cycle++;
      if (mon_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      // long back-pressure so the ALU fills and pushes back on its input
      if (mon_cycle == 300 || mon_cycle == 1000) holdoff_left = HoldOffCycles;

      if (holdoff_left > 0) begin
        holdoff_left--;
        holdoff_total++;
        next_ready = 1'b0;
      end else begin
        case (stall_mode)
          0: next_ready = 1'b1;
          1: next_ready = 1'($urandom_range(0, 1));
          2: next_ready = ($urandom_range(0, 3) == 0);
          default: next_ready = (mon_cycle % 3 == 0);
        endcase
      end
      rsp_if.ready <= next_ready;
    end
  end

  initial begin
    int unsigned pick;
    logic [2:0]  cmd;
    logic [7:0]  a;
    logic [7:0]  m;
    logic        d;

    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = 3'd0;
    req_if.register_value = 8'd0;
    req_if.operand = 8'd0;
    req_if.carry_in = 1'b0;
    req_if.decimal_mode = 1'b0;
    req_if.overflow_in = 1'b0;
    rsp_if.ready = 1'b0;

    // shifts and rotates: carry out, zero result, carry into rotates
    queue_request(OP_ASL, 8'h00, 8'h80, 1'b0, 1'b0, 1'b1);
    queue_request(OP_ASL, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
    queue_request(OP_LSR, 8'h00, 8'h01, 1'b0, 1'b0, 1'b1);
    queue_request(OP_LSR, 8'hFF, 8'hFE, 1'b1, 1'b0, 1'b0);
    queue_request(OP_ROL, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0);
    queue_request(OP_ROL, 8'h00, 8'h7F, 1'b0, 1'b0, 1'b1);
    queue_request(OP_ROR, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0);
    queue_request(OP_ROR, 8'h00, 8'hFE, 1'b0, 1'b1, 1'b1);
    // binary add: signed overflow, carry, wrap to zero
    queue_request(OP_ADC, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0);
    queue_request(OP_ADC, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1);
    queue_request(OP_ADC, 8'h80, 8'h80, 1'b0, 1'b0, 1'b0);
    // decimal add: low digit correction, high digit carry, non-BCD digits
    queue_request(OP_ADC, 8'h09, 8'h01, 1'b0, 1'b1, 1'b0);
    queue_request(OP_ADC, 8'h99, 8'h01, 1'b0, 1'b1, 1'b0);
    queue_request(OP_ADC, 8'h58, 8'h46, 1'b1, 1'b1, 1'b0);
    queue_request(OP_ADC, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
    // subtract: borrow, overflow, decimal borrow across both digits
    queue_request(OP_SBC, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0);
    queue_request(OP_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0);
    queue_request(OP_SBC, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0);
    queue_request(OP_SBC, 8'h10, 8'h01, 1'b1, 1'b1, 1'b0);
    queue_request(OP_SBC, 8'h46, 8'h12, 1'b0, 1'b1, 1'b1);
    // compare: equal, below, above
    queue_request(OP_CMP, 8'h40, 8'h40, 1'b0, 1'b0, 1'b1);
    queue_request(OP_CMP, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
    queue_request(OP_CMP, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
    // unused code passes the operand and the incoming carry and overflow flags
    queue_request(OpNop, 8'hAA, 8'h55, 1'b1, 1'b1, 1'b1);
    queue_request(OpNop, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);

    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) cmd = OpNop;
      else if (pick < 22) cmd = 3'($urandom_range(OP_ASL, OP_ROR));
      else if (pick < 50) cmd = OP_ADC;
      else if (pick < 78) cmd = OP_SBC;
      else cmd = OP_CMP;
      a = 8'($urandom);
      m = 8'($urandom);
      d = 1'($urandom_range(0, 1));
      // mostly proper BCD digits in decimal mode
      if (d && $urandom_range(0, 3) != 0) begin
        a = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        m = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      end
      if ($urandom_range(0, 15) == 0) m = a;
      queue_request(cmd, a, m, 1'($urandom_range(0, 1)), d, 1'($urandom_range(0, 1)));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d request beats (%0d decimal ADC/SBC, %0d unused opcode), checked %0d",
             sent_count, bcd_count, nop_count, checked_count);
    $display("results; receiver held off %0d cycles under back-pressure.", holdoff_total);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/csac_pkg.sv
hdl/csac_if.sv
hdl/csac_core.sv
hdl/cpu_alu_shift_add_compare.sv
test/testbench.sv
